// ===== src/phs_pkg.sv =====
// ----------------------------------------------------------------------------
// Profile hop sequencer package
// Codes, widths and limits shared by the sequencer and its checker.
// ----------------------------------------------------------------------------
package phs_pkg;

    localparam int MAX_PROFILES = 8;
    localparam int INDEX_SLOTS  = 8;

    localparam int INDEX_W  = 3;
    localparam int COUNT_W  = 4;
    localparam int MODE_W   = 2;
    localparam int PERIOD_W = 32;
    localparam int CMD_W    = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int COUNT_LIMIT_INT = (MAX_PROFILES < INDEX_SLOTS) ? MAX_PROFILES : INDEX_SLOTS;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_INT);

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROFILE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOP_MODE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_TICKS  = 2'd2;

    localparam logic [COUNT_W-1:0] PROFILE_COUNT_RESET = 4'd1;

    // Remainder of a small value by a count of one to eight.
    function automatic logic [COUNT_W-1:0] mod_small(input logic [COUNT_W-1:0] value,
                                                     input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] rem;
        rem = value;
        for (int i = 0; i < INDEX_SLOTS; i++)
        begin
            if (rem >= count)
            begin
                rem = rem - count;
            end
        end
        return rem;
    endfunction

endpackage

// ===== src/profile_hop_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Profile hop sequencer
// Chooses the active output profile from ticks, manual selects and restarts.
//
//   Channel   Direction  Signals                                   Width
//   s_axis    in         tvalid, tready, tdata (cmd, select_index)  8
//   m_axis    out        tvalid, tready, tdata (index, hopped)      8
//   cfg       in         valid, ready, index, data                  2 + 32
//
// One item is accepted per cycle while no stalled result holds it; each gives one result.
// The item passes an input register, then one compare-and-add step updates
// the hop state and loads the result register.
// Reset restores profile 0, upward direction, a zero count and the default
// registers. A stalled result holds the pipeline; an empty input register still
// takes an item while a finished result waits.
// ----------------------------------------------------------------------------
module profile_hop_sequencer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] cmd, [4:2] select_index, [7:5] zero
    input  logic [phs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] profile_index, [3] hopped, [7:4] zero
    output logic [phs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [phs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [phs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import phs_pkg::*;

    logic                    in_valid_reg;
    logic [CMD_W-1:0]        in_cmd_reg;
    logic [INDEX_W-1:0]      in_sel_reg;
    logic                    out_valid_reg;
    logic [INDEX_W-1:0]      out_index_reg;
    logic                    out_hopped_reg;

    logic [COUNT_W-1:0]      profile_count_reg;
    logic [MODE_W-1:0]       hop_mode_reg;
    logic [PERIOD_W-1:0]     period_ticks_reg;
    logic [INDEX_W-1:0]      index_reg;
    logic [INDEX_W-1:0]      index_next;
    logic                    going_up_reg;
    logic                    going_up_next;
    logic [PERIOD_W-1:0]     elapsed_reg;
    logic [PERIOD_W-1:0]     elapsed_next;
    logic                    hopped;

    logic                    res_free;
    logic                    fire;
    logic                    cfg_fire;
    logic [COUNT_W-1:0]      count_eff;
    logic                    hop_enable;
    logic [PERIOD_W:0]       tick_sum;
    logic                    tick_hit;
    logic [COUNT_W-1:0]      cycle_next;
    logic signed [4:0]       pp_step;
    logic signed [4:0]       pp_count;
    logic signed [4:0]       pp_pos;
    logic                    pp_up;

    assign res_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || res_free;
    assign fire          = in_valid_reg && res_free;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_hopped_reg, out_index_reg};

    always_comb
    begin
        if (profile_count_reg == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        else if (profile_count_reg > COUNT_LIMIT)
        begin
            count_eff = COUNT_LIMIT;
        end
        else
        begin
            count_eff = profile_count_reg;
        end
    end

    assign hop_enable = (hop_mode_reg == MODE_CYCLE || hop_mode_reg == MODE_PINGPONG)
                        && (period_ticks_reg != '0);
    assign tick_sum   = {1'b0, elapsed_reg} + (PERIOD_W+1)'(1);
    assign tick_hit   = tick_sum >= {1'b0, period_ticks_reg};
    assign cycle_next = mod_small({1'b0, index_reg} + COUNT_W'(1), count_eff);
    assign pp_count   = $signed({1'b0, count_eff});
    assign pp_step    = $signed({2'b00, index_reg}) + (going_up_reg ? 5'sd1 : -5'sd1);

    always_comb
    begin
        pp_pos = pp_step;
        pp_up  = going_up_reg;
        if (pp_pos >= pp_count)
        begin
            pp_pos = pp_count - 5'sd2;
            pp_up  = 1'b0;
        end
        if (pp_pos < 5'sd0)
        begin
            pp_pos = 5'sd1;
            pp_up  = 1'b1;
        end
        if (pp_pos >= pp_count)
        begin
            pp_pos = pp_count - 5'sd1;
        end
    end

    always_comb
    begin
        index_next    = index_reg;
        going_up_next = going_up_reg;
        elapsed_next  = elapsed_reg;
        hopped        = 1'b0;
        unique case (in_cmd_reg)
            CMD_TICK:
            begin
                if (hop_enable)
                begin
                    if (tick_hit)
                    begin
                        elapsed_next = '0;
                        hopped       = 1'b1;
                        if (hop_mode_reg == MODE_CYCLE)
                        begin
                            index_next = cycle_next[INDEX_W-1:0];
                        end
                        else
                        begin
                            index_next    = pp_pos[INDEX_W-1:0];
                            going_up_next = pp_up;
                        end
                    end
                    else
                    begin
                        elapsed_next = tick_sum[PERIOD_W-1:0];
                    end
                end
            end
            CMD_SELECT:
            begin
                if ({1'b0, in_sel_reg} < count_eff)
                begin
                    index_next = in_sel_reg;
                    hopped     = 1'b1;
                end
            end
            CMD_RESTART:
            begin
                index_next    = '0;
                going_up_next = 1'b1;
                elapsed_next  = '0;
                hopped        = 1'b1;
            end
            default:
            begin
                hopped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (res_free)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg <= s_axis_tdata[CMD_W-1:0];
            in_sel_reg <= s_axis_tdata[CMD_W+INDEX_W-1:CMD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_index_reg  <= index_next;
            out_hopped_reg <= hopped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_count_reg <= PROFILE_COUNT_RESET;
            hop_mode_reg      <= MODE_MANUAL;
            period_ticks_reg  <= '0;
            index_reg         <= '0;
            going_up_reg      <= 1'b1;
            elapsed_reg       <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_PROFILE_COUNT:
                begin
                    profile_count_reg <= cfg_data[COUNT_W-1:0];
                end
                CFG_HOP_MODE:
                begin
                    hop_mode_reg <= cfg_data[MODE_W-1:0];
                    elapsed_reg  <= '0;
                end
                CFG_PERIOD_TICKS:
                begin
                    period_ticks_reg <= cfg_data[PERIOD_W-1:0];
                    elapsed_reg      <= '0;
                end
                default:
                begin
                    profile_count_reg <= profile_count_reg;
                end
            endcase
        end
        else if (fire)
        begin
            index_reg    <= index_next;
            going_up_reg <= going_up_next;
            elapsed_reg  <= elapsed_next;
        end
    end

endmodule

// ===== src/phs_checker.sv =====
// ----------------------------------------------------------------------------
// Profile hop sequencer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module phs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [phs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import phs_pkg::*;

    logic [INDEX_W-1:0] last_index_reg;
    logic               out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg <= '0;
        end
        else if (out_xfer)
        begin
            last_index_reg <= m_axis_tdata[INDEX_W-1:0];
        end
    end

    // A result that does not hop leaves the profile where the last one left it.
    a_no_hop_keeps_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !m_axis_tdata[INDEX_W] |-> m_axis_tdata[INDEX_W-1:0] == last_index_reg)
        else $error("profile changed without a hop");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:INDEX_W+1] == '0)
        else $error("result padding bits not zero");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped before transfer");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

endmodule

bind profile_hop_sequencer_top phs_checker u_phs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/profile_hop_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Profile hop sequencer testbench
// Sends ticks, manual selects, restarts and unused commands through the input
// stream under random bursts, gaps and output stalls. Register writes are
// made between phases, once the block is idle. Every output transfer is
// compared field by field with a typed result or what an internal model expects.
// ----------------------------------------------------------------------------
module profile_hop_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phs_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam int                RANDOM_ITEMS = 1450;
    localparam int                MAX_REPORTS  = 10;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               hopped;
    } hop_result_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_INDEX_W-1:0] code;
        logic [CFG_DATA_W-1:0] value;
        logic                  known;
        hop_result_t           result;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    logic [COUNT_W-1:0]      reg_count = PROFILE_COUNT_RESET;
    logic [MODE_W-1:0]       reg_mode = MODE_MANUAL;
    logic [PERIOD_W-1:0]     reg_period = '0;
    logic [INDEX_W-1:0]      seq_index = '0;
    logic                    seq_up = 1'b1;
    logic [PERIOD_W-1:0]     seq_elapsed = '0;

    hop_result_t             expected_hops[$];
    stim_row_t               directed_rows[$];
    int                      mismatch_count = 0;
    int                      burst_left = 0;
    int unsigned             stall_style = 0;
    int unsigned             stall_left = 0;

    profile_hop_sequencer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_count();
        int n;
        n = int'(reg_count);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > COUNT_LIMIT_INT)
        begin
            n = COUNT_LIMIT_INT;
        end
        return n;
    endfunction

    task automatic advance_profile();
        int n;
        int nxt;
        n = active_count();
        if (reg_mode == MODE_CYCLE)
        begin
            seq_index = INDEX_W'((int'(seq_index) + 1) % n);
        end
        else
        begin
            nxt = int'(seq_index) + (seq_up ? 1 : -1);
            if (nxt >= n)
            begin
                nxt = n - 2;
                seq_up = 1'b0;
            end
            if (nxt < 0)
            begin
                nxt = 1;
                seq_up = 1'b1;
            end
            if (nxt >= n)
            begin
                nxt = n - 1;
            end
            seq_index = INDEX_W'(nxt);
        end
    endtask

    task automatic predict_hop(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] sel,
                               output hop_result_t res);
        logic [PERIOD_W:0] next_count;
        res.hopped = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                if ((reg_mode == MODE_CYCLE || reg_mode == MODE_PINGPONG) && reg_period != 0)
                begin
                    next_count = {1'b0, seq_elapsed} + 1'b1;
                    if (next_count >= {1'b0, reg_period})
                    begin
                        seq_elapsed = '0;
                        advance_profile();
                        res.hopped = 1'b1;
                    end
                    else
                    begin
                        seq_elapsed = next_count[PERIOD_W-1:0];
                    end
                end
            end
            CMD_SELECT:
            begin
                if (int'(sel) < active_count())
                begin
                    seq_index = sel;
                    res.hopped = 1'b1;
                end
            end
            CMD_RESTART:
            begin
                seq_index = '0;
                seq_up = 1'b1;
                seq_elapsed = '0;
                res.hopped = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.index = seq_index;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] sel,
                             input logic known, input hop_result_t typed);
        hop_result_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - INDEX_W - CMD_W){1'b0}}, sel, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_hop(cmd, sel, res);
        expected_hops.push_back(known ? typed : res);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_hops.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_PROFILE_COUNT:
            begin
                reg_count = data[COUNT_W-1:0];
            end
            CFG_HOP_MODE:
            begin
                reg_mode = data[MODE_W-1:0];
                seq_elapsed = '0;
            end
            CFG_PERIOD_TICKS:
            begin
                reg_period = data;
                seq_elapsed = '0;
            end
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic add_reg_row(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
        directed_rows.push_back({1'b1, index, data, 1'b0, INDEX_W'(0), 1'b0});
    endtask

    task automatic add_item_row(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] sel,
                                input logic known, input logic [INDEX_W-1:0] index,
                                input logic hopped);
        directed_rows.push_back({1'b0, CFG_INDEX_W'(cmd), CFG_DATA_W'(sel), known, index,
                                 hopped});
    endtask

    always @(posedge clk)
    begin
        case (stall_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= stall_left[3];
        endcase
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 96);
        end
        else
        begin
            stall_left = stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        hop_result_t got;
        hop_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.index  = m_axis_tdata[INDEX_W-1:0];
            got.hopped = m_axis_tdata[INDEX_W];
            if (expected_hops.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                begin
                    $display("unexpected transfer: index %0d hopped %0b", got.index,
                             got.hopped);
                end
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = expected_hops.pop_front();
                if (got.index !== want.index || got.hopped !== want.hopped)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("mismatch: index exp %0d got %0d, hopped exp %0b got %0b",
                                 want.index, got.index, want.hopped, got.hopped);
                    end
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        stim_row_t   row;
        hop_result_t typed;
        int          sent;
        int          phase_len;
        int          pick;
        logic [CMD_W-1:0]      cmd;
        logic [CFG_DATA_W-1:0] data;
        bit          first_phase;

        // Reset defaults: one profile, manual mode, no period.
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd0, 1'b0);
        add_item_row(CMD_SELECT,  3'd0, 1'b1, 3'd0, 1'b1);
        add_item_row(CMD_SELECT,  3'd7, 1'b1, 3'd0, 1'b0);
        add_item_row(CMD_UNUSED,  3'd5, 1'b1, 3'd0, 1'b0);
        add_item_row(CMD_RESTART, 3'd0, 1'b1, 3'd0, 1'b1);
        add_reg_row(CFG_PROFILE_COUNT, 32'd8);
        add_reg_row(CFG_HOP_MODE,      32'(MODE_CYCLE));
        add_reg_row(CFG_PERIOD_TICKS,  32'd1);
        add_item_row(CMD_SELECT,  3'd7, 1'b1, 3'd7, 1'b1);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd0, 1'b1);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd1, 1'b1);
        add_reg_row(CFG_PROFILE_COUNT, 32'd15);
        add_reg_row(CFG_HOP_MODE,      32'(MODE_PINGPONG));
        add_reg_row(CFG_PERIOD_TICKS,  32'd2);
        add_item_row(CMD_SELECT,  3'd6, 1'b1, 3'd6, 1'b1);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd6, 1'b0);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd7, 1'b1);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd7, 1'b0);
        add_item_row(CMD_TICK,    3'd0, 1'b0, 3'd0, 1'b0);
        add_reg_row(CFG_PROFILE_COUNT, 32'd0);
        add_reg_row(CFG_PERIOD_TICKS,  32'hFFFF_FFFF);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd6, 1'b0);
        add_item_row(CMD_SELECT,  3'd1, 1'b1, 3'd6, 1'b0);
        add_reg_row(CFG_PERIOD_TICKS,  32'd1);
        add_item_row(CMD_TICK,    3'd0, 1'b0, 3'd0, 1'b0);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd0, 1'b1);
        add_reg_row(CFG_PROFILE_COUNT, 32'd3);
        add_reg_row(CFG_HOP_MODE,      32'(MODE_CYCLE));
        add_item_row(CMD_SELECT,  3'd2, 1'b1, 3'd2, 1'b1);
        add_reg_row(CFG_PROFILE_COUNT, 32'd2);
        add_item_row(CMD_TICK,    3'd0, 1'b0, 3'd0, 1'b0);
        add_reg_row(CFG_HOP_MODE,      32'hFFFF_FFFF);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd1, 1'b0);
        add_item_row(CMD_SELECT,  3'd0, 1'b1, 3'd0, 1'b1);
        add_reg_row(CFG_HOP_MODE,      32'(MODE_MANUAL));
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd0, 1'b0);
        add_item_row(CMD_RESTART, 3'd7, 1'b1, 3'd0, 1'b1);
        add_reg_row(CFG_HOP_MODE,      32'(MODE_PINGPONG));
        add_reg_row(CFG_PROFILE_COUNT, 32'd4);
        add_reg_row(CFG_PERIOD_TICKS,  32'd3);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd0, 1'b0);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd0, 1'b0);
        add_item_row(CMD_TICK,    3'd0, 1'b1, 3'd1, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_reg)
            begin
                drain_results();
                write_reg(row.code, row.value);
            end
            else
            begin
                pace_sender();
                send_item(row.code, row.value[INDEX_W-1:0], row.known, row.result);
            end
        end

        sent = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            if (first_phase || $urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 9);
                data = (pick == 0) ? (($urandom_range(0, 1) != 0) ? 32'd0
                                                                   : 32'($urandom_range(9, 15)))
                                   : 32'($urandom_range(1, 8));
                if ($urandom_range(0, 3) == 0)
                begin
                    data[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W-COUNT_W)'($urandom());
                end
                write_reg(CFG_PROFILE_COUNT, data);
            end
            if (first_phase || $urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 9);
                data = (pick == 0) ? 32'(MODE_MANUAL) :
                       (pick == 1) ? 32'(MODE_UNUSED) :
                       (pick < 6)  ? 32'(MODE_CYCLE) : 32'(MODE_PINGPONG);
                if ($urandom_range(0, 3) == 0)
                begin
                    data[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W-MODE_W)'($urandom());
                end
                write_reg(CFG_HOP_MODE, data);
            end
            if (first_phase || $urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 19);
                data = (pick == 0) ? 32'd0 :
                       (pick == 1) ? 32'hFFFF_FFFF :
                       (pick == 2) ? 32'($urandom()) :
                       (pick < 6)  ? 32'($urandom_range(5, 20)) : 32'($urandom_range(1, 4));
                write_reg(CFG_PERIOD_TICKS, data);
            end
            first_phase = 1'b0;

            phase_len = $urandom_range(20, 60);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 99) == 0)
                begin
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                cmd = (pick < 55) ? CMD_TICK :
                      (pick < 80) ? CMD_SELECT :
                      (pick < 93) ? CMD_RESTART : CMD_UNUSED;
                pace_sender();
                typed = '0;
                send_item(cmd, INDEX_W'($urandom_range(0, 7)), 1'b0, typed);
                sent = sent + 1;
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_hops.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== profile_hop_sequencer_top.f =====
src/phs_pkg.sv
src/profile_hop_sequencer_top.sv
src/phs_checker.sv
sim/profile_hop_sequencer_top_tb.sv
